FILE: design/breakpoint_table_halt_unit_defines.svh
// Assertion macros used by the breakpoint table halt unit checker.
`ifndef BREAKPOINT_TABLE_HALT_UNIT_DEFINES_SVH
`define BREAKPOINT_TABLE_HALT_UNIT_DEFINES_SVH

// Property checked on clk, ignored while rst_n is low.
`define BTHU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bthu check failed");

// Property checked on clk at every edge, reset included.
`define BTHU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bthu check failed");

`endif

FILE: design/bthu_pkg.sv
// Shared constants, codes and types of the breakpoint table halt unit.
package bthu_pkg;

  localparam int MAX_BREAKPOINTS = 16;
  localparam int SLOT_W          = $clog2(MAX_BREAKPOINTS);
  localparam int COUNT_W         = $clog2(MAX_BREAKPOINTS + 1);

  localparam int MARGIN_W        = 20;
  localparam int CFG_IDX_W       = 1;
  localparam logic [MARGIN_W-1:0] RESET_MARGIN = 20'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACHED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 1'd1;

  // commands
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_SET_EN = 3'd2;
  localparam logic [2:0] OP_CLEAR  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // condition kinds
  localparam logic [2:0] KIND_ADDR   = 3'd0;
  localparam logic [2:0] KIND_TIME   = 3'd1;
  localparam logic [2:0] KIND_CYCLES = 3'd2;
  localparam logic [2:0] KIND_FRAMES = 3'd3;
  localparam logic [2:0] KIND_JAM    = 3'd4;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // field widths of the stream payloads
  localparam int IN_DATA_W  = 288;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  kind;
    logic        en;
  } entry_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [COUNT_W-1:0] at;
    logic               flag;
    logic [2:0]         kind;
    logic [63:0]        value;
  } cmd_t;

  typedef struct packed {
    logic        sync;
    logic [15:0] addr;
    logic [63:0] cycles;
    logic [63:0] frames;
    logic [63:0] time_us;
    logic        jammed;
  } tick_t;

endpackage

FILE: design/breakpoint_table_halt_unit.sv
// Top level of the breakpoint table halt unit.
//
// Input items arrive on in_tvalid/in_tready with the command in in_tuser and
// the remaining fields in in_tdata. Each item yields one result on
// out_tvalid/out_tready. Registers are written on cfg_valid/cfg_ready
// (cfg_ready is always high): index 0 cpu_attached, index 1 time_margin.
//
// An item passes the capture, cell and pick steps of the control sequencer:
// one to capture it, one in which every table cell updates its entry or
// evaluates its condition in parallel, and one in which the lowest
// matching cell is picked and the result register is loaded. The result
// is valid the cycle after that; the next item is taken in that same
// cycle. No new item is taken before the last one has loaded its result.
//
// A result that is not taken holds in the output register; the unit still
// accepts and processes the next item and waits in its last step until
// the register frees. Synchronous reset (rst_n low) empties the table,
// clears the halt, the output and the registers to their reset values.
module breakpoint_table_halt_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bthu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bthu_pkg::MARGIN_W-1:0]     cfg_data,
  // input items
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command
  input  logic [2:0]                        in_tuser,
  // slot_index[3:0], enable_flag[4], cond_kind[7:5], cond_value[71:8],
  // cpu_sync[72], inst_addr[88:73], cycle_count[152:89],
  // frame_count[216:153], emu_time_us[280:217], cpu_jammed[281], zero fill
  input  logic [bthu_pkg::IN_DATA_W-1:0]    in_tdata,
  // result items
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[1:0], halt_active[2], halt_slot[6:3], halt_request[7],
  // entry_count[12:8], zero fill
  output logic [bthu_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  localparam int N = bthu_pkg::MAX_BREAKPOINTS;

  logic [1:0] state_r, state_nxt;

  bthu_pkg::cmd_t  cmd_r;
  bthu_pkg::tick_t tick_r;

  logic                           attached_r;
  logic [bthu_pkg::MARGIN_W-1:0]  margin_r;
  logic [bthu_pkg::COUNT_W-1:0]   used_r, used_nxt;
  logic                           halted_r, halted_nxt;
  logic [bthu_pkg::SLOT_W-1:0]    hslot_r, hslot_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [bthu_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic [1:0] status;
  logic       request;
  logic       load_out;

  bthu_pkg::entry_t entries [N];
  logic [N-1:0]     match;
  logic             found;
  logic [bthu_pkg::SLOT_W-1:0] found_slot;

  assign cfg_ready  = 1'b1;
  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= 1'b0;
      margin_r   <= bthu_pkg::RESET_MARGIN;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bthu_pkg::CFG_ATTACHED) begin
        attached_r <= cfg_data[0];
      end else if (cfg_index == bthu_pkg::CFG_MARGIN) begin
        margin_r <= cfg_data;
      end
    end
  end

  // capture of an accepted item
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r.op      <= in_tuser;
      cmd_r.at      <= bthu_pkg::COUNT_W'(in_tdata[3:0]);
      cmd_r.flag    <= in_tdata[4];
      cmd_r.kind    <= in_tdata[7:5];
      cmd_r.value   <= in_tdata[71:8];
      tick_r.sync   <= in_tdata[72];
      tick_r.addr   <= in_tdata[88:73];
      tick_r.cycles <= in_tdata[152:89];
      tick_r.frames <= in_tdata[216:153];
      tick_r.time_us <= in_tdata[280:217];
      tick_r.jammed <= in_tdata[281];
    end
  end

  // row of cells, each shifting from its upper neighbor
  for (genvar g = 0; g < N; g++) begin : g_cell
    bthu_pkg::entry_t nbr;
    if (g == N - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entries[g+1];
    end
    bthu_cell u_cell (
      .clk        (clk),
      .exec       (state_r == S_EXEC),
      .cell_idx   (bthu_pkg::SLOT_W'(g)),
      .used_count (used_r),
      .cmd        (cmd_r),
      .tick       (tick_r),
      .margin     (margin_r),
      .nbr_in     (nbr),
      .entry_out  (entries[g]),
      .match_out  (match[g])
    );
  end

  bthu_pick u_pick (
    .match (match),
    .found (found),
    .slot  (found_slot)
  );

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // table count, halt record and result on the last step
  always_comb begin
    used_nxt   = used_r;
    halted_nxt = halted_r;
    hslot_nxt  = hslot_r;
    status     = bthu_pkg::ST_OK;
    request    = 1'b0;
    unique case (cmd_r.op)
      bthu_pkg::OP_ADD: begin
        if (used_r >= bthu_pkg::COUNT_W'(N)) begin
          status = bthu_pkg::ST_FULL;
        end else begin
          used_nxt = used_r + bthu_pkg::COUNT_W'(1);
        end
      end
      bthu_pkg::OP_REMOVE: begin
        if (cmd_r.at >= used_r) begin
          status = bthu_pkg::ST_RANGE;
        end else begin
          used_nxt = used_r - bthu_pkg::COUNT_W'(1);
          if (halted_r) begin
            if (bthu_pkg::COUNT_W'(hslot_r) == cmd_r.at) begin
              halted_nxt = 1'b0;
              hslot_nxt  = '0;
            end else if (bthu_pkg::COUNT_W'(hslot_r) > cmd_r.at) begin
              hslot_nxt = hslot_r - bthu_pkg::SLOT_W'(1);
            end
          end
        end
      end
      bthu_pkg::OP_SET_EN: begin
        if (cmd_r.at >= used_r) begin
          status = bthu_pkg::ST_RANGE;
        end
      end
      bthu_pkg::OP_CLEAR: begin
        used_nxt   = '0;
        halted_nxt = 1'b0;
        hslot_nxt  = '0;
      end
      bthu_pkg::OP_TICK: begin
        if (attached_r) begin
          if (!halted_r && found) begin
            halted_nxt = 1'b1;
            hslot_nxt  = found_slot;
            request    = 1'b1;
          end else begin
            halted_nxt = 1'b0;
            hslot_nxt  = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt = {3'd0, 5'(used_nxt), request,
                    (halted_nxt ? 4'(hslot_nxt) : 4'd0), halted_nxt, status};
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      halted_r    <= 1'b0;
      hslot_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        used_r   <= used_nxt;
        halted_r <= halted_nxt;
        hslot_r  <= hslot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

FILE: design/bthu_cell.sv
// One table cell: holds one breakpoint, shifts from its upper neighbor, evaluates its match.
module bthu_cell (
  input  logic                           clk,
  input  logic                           exec,
  input  logic [bthu_pkg::SLOT_W-1:0]    cell_idx,
  input  logic [bthu_pkg::COUNT_W-1:0]   used_count,
  input  bthu_pkg::cmd_t                 cmd,
  input  bthu_pkg::tick_t                tick,
  input  logic [bthu_pkg::MARGIN_W-1:0]  margin,
  input  bthu_pkg::entry_t               nbr_in,
  output bthu_pkg::entry_t               entry_out,
  output logic                           match_out
);

  bthu_pkg::entry_t entry_r, entry_nxt;
  logic             match_r, match_nxt;
  logic             hit;
  logic [bthu_pkg::COUNT_W-1:0] idx;
  logic [bthu_pkg::COUNT_W-1:0] idx_plus1;
  logic             in_use;
  logic             at_ok;

  assign idx       = bthu_pkg::COUNT_W'(cell_idx);
  assign idx_plus1 = idx + bthu_pkg::COUNT_W'(1);
  assign in_use    = idx < used_count;
  assign at_ok     = cmd.at < used_count;

  // condition of the stored entry against the current tick
  always_comb begin
    unique case (entry_r.kind)
      bthu_pkg::KIND_ADDR:   hit = tick.sync && (entry_r.value == {48'd0, tick.addr});
      bthu_pkg::KIND_TIME:   hit = (tick.time_us >= entry_r.value) &&
                                   ((tick.time_us - entry_r.value) >= {44'd0, margin});
      bthu_pkg::KIND_CYCLES: hit = tick.cycles == entry_r.value;
      bthu_pkg::KIND_FRAMES: hit = tick.frames == entry_r.value;
      bthu_pkg::KIND_JAM:    hit = tick.jammed;
      default:               hit = 1'b0;
    endcase
  end

  // entry update per command
  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    if (exec) begin
      unique case (cmd.op)
        bthu_pkg::OP_ADD: begin
          if (idx == used_count) begin
            entry_nxt.value = cmd.value;
            entry_nxt.kind  = cmd.kind;
            entry_nxt.en    = 1'b1;
          end
        end
        bthu_pkg::OP_REMOVE: begin
          if (at_ok && idx >= cmd.at && idx_plus1 < used_count) begin
            entry_nxt = nbr_in;
          end
        end
        bthu_pkg::OP_SET_EN: begin
          if (at_ok && idx == cmd.at) begin
            entry_nxt.en = cmd.flag;
          end
        end
        bthu_pkg::OP_TICK: begin
          match_nxt = entry_r.en && in_use && hit;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry_out = entry_r;
  assign match_out = match_r;

endmodule

FILE: design/bthu_pick.sv
// Priority pick of the lowest matching cell.
module bthu_pick (
  input  logic [bthu_pkg::MAX_BREAKPOINTS-1:0] match,
  output logic                                 found,
  output logic [bthu_pkg::SLOT_W-1:0]          slot
);

  // scan from the top so the lowest index wins
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = bthu_pkg::MAX_BREAKPOINTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        slot  = bthu_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

FILE: design/bthu_checker.sv
// Port-level checks of the breakpoint table halt unit, bound to the top level.
`include "breakpoint_table_halt_unit_defines.svh"

module bthu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bthu_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a waiting result holds
  `BTHU_ASSERT(a_out_hold, (out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)))
  // a new halt request is always reported with the halt recorded
  `BTHU_ASSERT(a_req_active, (out_tvalid && out_tdata[7] |-> out_tdata[2]))
  // no halt slot without a halt, the count never passes capacity, and no status code 3
  `BTHU_ASSERT(a_slot_count, (out_tvalid |-> (out_tdata[2] || out_tdata[6:3] == 4'd0) &&
    (out_tdata[12:8] <= 5'(bthu_pkg::MAX_BREAKPOINTS)) && (out_tdata[1:0] != 2'd3)))
  // reset empties the output register
  `BTHU_ASSERT_ALWAYS(a_reset_out, (!rst_n |=> !out_tvalid))

endmodule

bind breakpoint_table_halt_unit bthu_checker u_bthu_checker (.*);

FILE: sim/bthu_result_checker.sv
// Checker that mirrors the breakpoint table and compares every result item.
module bthu_result_checker
  import bthu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MARGIN_W-1:0]   cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // command
  input  logic [2:0]            in_tuser,
  // slot_index[3:0], enable_flag[4], cond_kind[7:5], cond_value[71:8],
  // cpu_sync[72], inst_addr[88:73], cycle_count[152:89],
  // frame_count[216:153], emu_time_us[280:217], cpu_jammed[281], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // status[1:0], halt_active[2], halt_slot[6:3], halt_request[7],
  // entry_count[12:8], zero fill
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 200;

  // mirrored table, halt record and registers
  logic [63:0]           tbl_value [MAX_BREAKPOINTS];
  logic [2:0]            tbl_kind  [MAX_BREAKPOINTS];
  logic                  tbl_en    [MAX_BREAKPOINTS];
  int unsigned           tbl_used;
  logic                  halt_valid;
  logic [SLOT_W-1:0]     halt_idx;
  logic                  attached;
  logic [MARGIN_W-1:0]   margin;
  logic [OUT_DATA_W-1:0] expected_results [$];

  task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
    if (mismatches < PRINT_CAP)
      $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, want_v, got_v);
    mismatches++;
  endtask

  // condition of one entry against the tick fields
  function automatic bit entry_hits(input int i, input logic [IN_DATA_W-1:0] d);
    logic [63:0] now_us;
    now_us = d[280:217];
    case (tbl_kind[i])
      KIND_ADDR:   return d[72] && ({48'd0, d[88:73]} == tbl_value[i]);
      KIND_TIME:   return (now_us >= tbl_value[i]) &&
                          ((now_us - tbl_value[i]) >= {44'd0, margin});
      KIND_CYCLES: return d[152:89] == tbl_value[i];
      KIND_FRAMES: return d[216:153] == tbl_value[i];
      KIND_JAM:    return d[281];
      default:     return 1'b0;
    endcase
  endfunction

  // apply one item to the mirror and build the result it should produce
  function automatic logic [OUT_DATA_W-1:0] step_breakpoint_table(
    input logic [2:0] op, input logic [IN_DATA_W-1:0] d);
    logic [1:0]        status;
    logic              raised;
    logic [SLOT_W-1:0] at;
    int                hit;
    status = ST_OK;
    raised = 1'b0;
    at     = d[3:0];
    hit    = -1;
    case (op)
      OP_ADD: begin
        if (tbl_used >= MAX_BREAKPOINTS) begin
          status = ST_FULL;
        end else begin
          tbl_value[tbl_used] = d[71:8];
          tbl_kind[tbl_used]  = d[7:5];
          tbl_en[tbl_used]    = 1'b1;
          tbl_used++;
        end
      end
      OP_REMOVE: begin
        if (at >= tbl_used) begin
          status = ST_RANGE;
        end else begin
          // later entries close the gap
          for (int i = int'(at); i + 1 < tbl_used; i++) begin
            tbl_value[i] = tbl_value[i+1];
            tbl_kind[i]  = tbl_kind[i+1];
            tbl_en[i]    = tbl_en[i+1];
          end
          tbl_used--;
          if (halt_valid) begin
            if (halt_idx == at) begin
              halt_valid = 1'b0;
              halt_idx   = '0;
            end else if (halt_idx > at) begin
              halt_idx = halt_idx - 1'b1;
            end
          end
        end
      end
      OP_SET_EN: begin
        if (at >= tbl_used) status = ST_RANGE;
        else tbl_en[at] = d[4];
      end
      OP_CLEAR: begin
        tbl_used   = 0;
        halt_valid = 1'b0;
        halt_idx   = '0;
      end
      OP_TICK: begin
        if (attached) begin
          // a pending halt blocks the search and is released instead
          if (!halt_valid) begin
            for (int i = 0; i < tbl_used; i++) begin
              if (tbl_en[i] && entry_hits(i, d)) begin
                hit = i;
                break;
              end
            end
          end
          if (hit >= 0) begin
            halt_valid = 1'b1;
            halt_idx   = hit[SLOT_W-1:0];
            raised     = 1'b1;
          end else begin
            halt_valid = 1'b0;
            halt_idx   = '0;
          end
        end
      end
      default: ;
    endcase
    return {3'd0, tbl_used[COUNT_W-1:0], raised,
            halt_valid ? halt_idx : {SLOT_W{1'b0}}, halt_valid, status};
  endfunction

  // monitor all three channels
  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] want;
    if (!rst_n) begin
      tbl_used   = 0;
      halt_valid = 1'b0;
      halt_idx   = '0;
      attached   = 1'b0;
      margin     = RESET_MARGIN;
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ATTACHED) attached = cfg_data[0];
        else if (cfg_index == CFG_MARGIN) margin = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unrequested result", 64'd0, 64'(out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[1:0] != want[1:0])
            report_mismatch("status", 64'(want[1:0]), 64'(out_tdata[1:0]));
          if (out_tdata[2] != want[2])
            report_mismatch("halt_active", 64'(want[2]), 64'(out_tdata[2]));
          if (out_tdata[6:3] != want[6:3])
            report_mismatch("halt_slot", 64'(want[6:3]), 64'(out_tdata[6:3]));
          if (out_tdata[7] != want[7])
            report_mismatch("halt_request", 64'(want[7]), 64'(out_tdata[7]));
          if (out_tdata[12:8] != want[12:8])
            report_mismatch("entry_count", 64'(want[12:8]), 64'(out_tdata[12:8]));
          if (out_tdata[15:13] != want[15:13])
            report_mismatch("fill bits", 64'(want[15:13]), 64'(out_tdata[15:13]));
        end
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(step_breakpoint_table(in_tuser, in_tdata));
      outstanding <= expected_results.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// Stimulus, clocking and verdict for the breakpoint table halt unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bthu_pkg::*;

  localparam logic [2:0]  OP_SPARE_FIRST   = 3'd5;
  localparam logic [2:0]  OP_SPARE_LAST    = 3'd7;
  localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0]  KIND_SPARE_LAST  = 3'd7;
  localparam logic [63:0] ALL_ONES         = '1;
  localparam logic [MARGIN_W-1:0] MARGIN_MAX = 20'd1000000;
  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int PRESSURE_CYCLES = 400;
  localparam int POOL_SIZE       = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [MARGIN_W-1:0]   cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [2:0]            in_tuser = '0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatches;
  int                    outstanding;

  int                    idle_cycles = 0;
  bit                    dense = 1'b0;
  bit                    pressure_go = 1'b0;
  logic [MARGIN_W-1:0]   margin_now = RESET_MARGIN;
  logic [63:0]           value_pool [POOL_SIZE];

  breakpoint_table_halt_unit dut (.*);

  bthu_result_checker checker_i (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pool_pick();
    return value_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(
    input logic [3:0] slot, input logic flag, input logic [2:0] kind,
    input logic [63:0] value, input logic sync, input logic [15:0] addr,
    input logic [63:0] cycles, input logic [63:0] frames,
    input logic [63:0] time_us, input logic jammed);
    return {{(IN_DATA_W - 282){1'b0}}, jammed, time_us, frames, cycles, addr, sync,
            value, kind, flag, slot};
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = dense ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic add_entry(input logic [2:0] kind, input logic [63:0] value);
    send_item(OP_ADD, pack_item(4'd0, 1'b0, kind, value, 1'b0, 16'd0, 64'd0, 64'd0,
                                64'd0, 1'b0));
  endtask

  task automatic slot_command(input logic [2:0] op, input logic [3:0] slot,
                              input logic flag);
    send_item(op, pack_item(slot, flag, 3'd0, 64'd0, 1'b0, 16'd0, 64'd0, 64'd0,
                            64'd0, 1'b0));
  endtask

  task automatic check_tick(input logic sync, input logic [15:0] addr,
                            input logic [63:0] cycles, input logic [63:0] frames,
                            input logic [63:0] time_us, input logic jammed);
    send_item(OP_TICK, pack_item(4'd0, 1'b0, 3'd0, 64'd0, sync, addr, cycles, frames,
                                 time_us, jammed));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [MARGIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // every result in, so the unit is idle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_registers(input logic attach, input logic [MARGIN_W-1:0] margin_val);
    wait_idle();
    write_reg(CFG_ATTACHED, {{(MARGIN_W - 1){1'b0}}, attach});
    write_reg(CFG_MARGIN, margin_val);
    cfg_valid  <= 1'b0;
    margin_now = margin_val;
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(0, 7))
        0:       value_pool[i] = '0;
        1:       value_pool[i] = ALL_ONES;
        2:       value_pool[i] = 64'($urandom_range(0, 255));
        default: value_pool[i] = rand_word();
      endcase
    end
  endtask

  // random item; tick fields lean on the value pool so entries really hit
  task automatic send_random_item(input bit only_add);
    int          r;
    logic [2:0]  op;
    logic [2:0]  kind;
    logic [63:0] value;
    logic [63:0] base;
    logic [63:0] jitter;
    logic [63:0] cycles;
    logic [63:0] frames;
    logic [63:0] time_us;
    logic [15:0] addr;
    r = $urandom_range(0, 99);
    if (only_add || r < 30) op = OP_ADD;
    else if (r < 45) op = OP_REMOVE;
    else if (r < 55) op = OP_SET_EN;
    else if (r < 57) op = OP_CLEAR;
    else if (r < 98) op = OP_TICK;
    else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    if ($urandom_range(0, 9) == 0)
      kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
    else kind = 3'($urandom_range(KIND_ADDR, KIND_JAM));
    value = ($urandom_range(0, 3) == 0) ? rand_word() : pool_pick();
    if (kind == KIND_ADDR && $urandom_range(0, 4) != 0) value = {48'd0, value[15:0]};
    base   = pool_pick();
    addr   = $urandom_range(0, 1) ? base[15:0] : 16'($urandom);
    cycles = ($urandom_range(0, 4) < 2) ? pool_pick() : rand_word();
    frames = ($urandom_range(0, 4) < 2) ? pool_pick() : rand_word();
    base   = pool_pick();
    jitter = 64'($urandom_range(0, 4));
    if ($urandom_range(0, 4) < 2) time_us = base + {44'd0, margin_now} + jitter - 64'd2;
    else time_us = rand_word();
    send_item(op, pack_item(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), kind,
                            value, $urandom_range(0, 3) != 0, addr, cycles, frames,
                            time_us, $urandom_range(0, 11) == 0));
  endtask

  task automatic run_phase(input int count);
    int n;
    int since_mode;
    n = 0;
    since_mode = 0;
    while (n < count) begin
      if (since_mode == 0) begin
        dense = ($urandom_range(0, 3) == 0);
        since_mode = 40;
      end
      // now and then fill the table past its capacity
      if ($urandom_range(0, 49) == 0) begin
        repeat (MAX_BREAKPOINTS + 1) send_random_item(1'b1);
        n += MAX_BREAKPOINTS + 1;
        since_mode = 0;
      end else begin
        send_random_item(1'b0);
        n++;
        since_mode--;
      end
    end
  endtask

  // result side: random stalls, one long hold-off once the random part starts
  initial begin
    int hold;
    bit pressure_done;
    pressure_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (pressure_go && !pressure_done) begin
        pressure_done = 1'b1;
        hold = PRESSURE_CYCLES;
      end else begin
        hold = gap_len();
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                          : $urandom_range(1, 20)) @(posedge clk);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // detached CPU: the tick changes nothing
    add_entry(KIND_JAM, 64'd0);
    check_tick(1'b0, 16'd0, 64'd0, 64'd0, 64'd0, 1'b1);
    set_registers(1'b1, 20'd0);

    // jam halts, the next tick with a halt pending releases it
    check_tick(1'b0, 16'd0, 64'd0, 64'd0, 64'd0, 1'b1);
    check_tick(1'b0, 16'd0, 64'd0, 64'd0, 64'd0, 1'b1);

    // address with upper bits set never hits
    add_entry(KIND_ADDR, 64'hFFFF_0000_0000_1234);
    add_entry(KIND_ADDR, 64'h0000_0000_0000_FFFF);
    add_entry(KIND_TIME, ALL_ONES);
    add_entry(KIND_CYCLES, ALL_ONES);
    add_entry(KIND_FRAMES, 64'd0);
    add_entry(KIND_SPARE_LAST, 64'd0);
    slot_command(OP_SET_EN, 4'd0, 1'b0);

    // disabled jam skipped, address wins over the later frame match
    check_tick(1'b1, 16'hFFFF, 64'd0, 64'd0, 64'd0, 1'b1);
    // remove ahead of the halt moves it down, removing the halting entry clears it
    slot_command(OP_REMOVE, 4'd0, 1'b0);
    slot_command(OP_REMOVE, 4'd1, 1'b0);
    slot_command(OP_SET_EN, 4'd15, 1'b1);
    slot_command(OP_REMOVE, 4'd15, 1'b0);

    // time at the top of the range with zero margin
    check_tick(1'b0, 16'd0, ALL_ONES, 64'd0, ALL_ONES, 1'b0);
    send_item(OP_SPARE_FIRST, '0);
    send_item(OP_SPARE_LAST, '1);
    slot_command(OP_CLEAR, 4'd0, 1'b0);

    // random phases over several register settings
    refresh_pool();
    set_registers(1'b1, MARGIN_MAX);
    pressure_go = 1'b1;
    run_phase(150);

    refresh_pool();
    set_registers(1'b1, 20'd1);
    run_phase(150);

    set_registers(1'b0, 20'($urandom_range(0, MARGIN_MAX)));
    run_phase(60);

    refresh_pool();
    set_registers(1'b1, 20'($urandom_range(0, MARGIN_MAX)));
    run_phase(240);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/bthu_pkg.sv
design/bthu_cell.sv
design/bthu_pick.sv
design/breakpoint_table_halt_unit.sv
design/bthu_checker.sv
sim/bthu_result_checker.sv
sim/tb_top.sv
